/* design/ray_aabb_overlap_test_core_assert.svh */
// Assertion macros for the ray/box overlap test core
`ifndef RAY_AABB_OVERLAP_TEST_CORE_ASSERT_SVH
`define RAY_AABB_OVERLAP_TEST_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RAO_ASSERT_IMPLY(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RAO_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* design/rao_pkg.sv */
// Shared widths, edge-axis tables and stage word types for the overlap test
`timescale 1ns / 1ps
package rao_pkg;

    localparam int CW  = 32;
    localparam int HW  = CW + 1;
    localparam int CCW = CW + 2;
    localparam int PW  = 2 * CW + 2;
    localparam int SW  = PW + 1;
    localparam int AW  = SW + 1;
    localparam int NAX = 3;
    localparam int NED = 3;

    // axis pair of each edge test: (y,z), (x,z), (x,y)
    localparam int EDGE_A [NED] = '{1, 0, 0};
    localparam int EDGE_B [NED] = '{2, 2, 1};

    typedef struct packed {
        logic                      valid;
        logic [NAX-1:0][HW-1:0]    h2;
        logic [NAX-1:0][CCW-1:0]   c2;
        logic [NAX-1:0][CW-1:0]    d;
        logic [NAX-1:0][CW-1:0]    dmag;
    } t_prep;

    typedef struct packed {
        logic                      valid;
        logic                      face_miss;
        logic [NED-1:0][PW-1:0]    lha;
        logic [NED-1:0][PW-1:0]    lhb;
        logic [NED-1:0][PW-1:0]    cra;
        logic [NED-1:0][PW-1:0]    crb;
    } t_prod;

    typedef struct packed {
        logic                      valid;
        logic                      face_miss;
        logic [NED-1:0][SW-1:0]    lhs;
        logic [NED-1:0][SW-1:0]    diff;
    } t_sum;

endpackage

/* design/rao_prep.sv */
// Stage 1: doubled half extents, doubled center offsets, direction magnitudes
`timescale 1ns / 1ps
module rao_prep
    import rao_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [NAX-1:0][CW-1:0]    i_origin,
    input  logic [NAX-1:0][CW-1:0]    i_dir,
    input  logic [NAX-1:0][CW-1:0]    i_bmin,
    input  logic [NAX-1:0][CW-1:0]    i_bmax,
    output t_prep                     o_prep
);

    t_prep n_prep;
    t_prep r_prep;

    always_comb begin
        n_prep.valid = i_valid && i_rst_n;
        for (int a = 0; a < NAX; a++) begin
            n_prep.h2[a] = {i_bmax[a][CW-1], i_bmax[a]} - {i_bmin[a][CW-1], i_bmin[a]};
            n_prep.c2[a] = {i_origin[a][CW-1], i_origin[a], 1'b0}
                         - {{2{i_bmin[a][CW-1]}}, i_bmin[a]}
                         - {{2{i_bmax[a][CW-1]}}, i_bmax[a]};
            n_prep.d[a]    = i_dir[a];
            n_prep.dmag[a] = i_dir[a][CW-1] ? (CW'(0) - i_dir[a]) : i_dir[a];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    assign o_prep = r_prep;

endmodule

/* design/rao_mul.sv */
// Stage 2: face tests and the four products of each edge test
`timescale 1ns / 1ps
module rao_mul
    import rao_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_prep    i_prep,
    output t_prod    o_prod
);

    logic signed [CCW:0]   c_ext    [NAX];
    logic signed [CCW:0]   c_abs    [NAX];
    logic signed [CCW:0]   h_ext    [NAX];
    logic                  opposite [NAX];
    logic [NAX-1:0]        face;
    logic signed [PW-1:0]  p_lha    [NED];
    logic signed [PW-1:0]  p_lhb    [NED];
    logic signed [PW-1:0]  p_cra    [NED];
    logic signed [PW-1:0]  p_crb    [NED];

    t_prod n_prod;
    t_prod r_prod;

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            c_ext[a] = $signed({i_prep.c2[a][CCW-1], i_prep.c2[a]});
            c_abs[a] = c_ext[a][CCW] ? -c_ext[a] : c_ext[a];
            h_ext[a] = $signed({{2{i_prep.h2[a][HW-1]}}, i_prep.h2[a]});
            opposite[a] = (c_ext[a] > 0 && i_prep.d[a][CW-1])
                       || (c_ext[a][CCW] && !i_prep.d[a][CW-1] && (i_prep.d[a] != '0));
            face[a] = (h_ext[a] < c_abs[a]) && !opposite[a];
        end
        for (int e = 0; e < NED; e++) begin
            p_lha[e] = $signed(i_prep.h2[EDGE_A[e]]) * $signed({1'b0, i_prep.dmag[EDGE_B[e]]});
            p_lhb[e] = $signed(i_prep.h2[EDGE_B[e]]) * $signed({1'b0, i_prep.dmag[EDGE_A[e]]});
            p_cra[e] = $signed(i_prep.c2[EDGE_A[e]]) * $signed(i_prep.d[EDGE_B[e]]);
            p_crb[e] = $signed(i_prep.c2[EDGE_B[e]]) * $signed(i_prep.d[EDGE_A[e]]);
            n_prod.lha[e] = p_lha[e];
            n_prod.lhb[e] = p_lhb[e];
            n_prod.cra[e] = p_cra[e];
            n_prod.crb[e] = p_crb[e];
        end
        n_prod.valid     = i_prep.valid && i_rst_n;
        n_prod.face_miss = |face;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

/* design/rao_acc.sv */
// Stage 3: projected extent sums and cross-product differences
`timescale 1ns / 1ps
module rao_acc
    import rao_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_prod    i_prod,
    output t_sum     o_sum
);

    logic signed [SW-1:0] s_lhs  [NED];
    logic signed [SW-1:0] s_diff [NED];

    t_sum n_sum;
    t_sum r_sum;

    always_comb begin
        for (int e = 0; e < NED; e++) begin
            s_lhs[e]  = $signed(i_prod.lha[e]) + $signed(i_prod.lhb[e]);
            s_diff[e] = $signed(i_prod.cra[e]) - $signed(i_prod.crb[e]);
            n_sum.lhs[e]  = s_lhs[e];
            n_sum.diff[e] = s_diff[e];
        end
        n_sum.valid     = i_prod.valid && i_rst_n;
        n_sum.face_miss = i_prod.face_miss;
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

/* design/rao_cmp.sv */
// Stage 4: edge compares, hit merge and result register
`timescale 1ns / 1ps
module rao_cmp
    import rao_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sum    i_sum,
    output logic    o_valid,
    output logic    o_hit
);

    logic signed [AW-1:0] l_ext [NED];
    logic signed [AW-1:0] d_ext [NED];
    logic signed [AW-1:0] d_abs [NED];
    logic [NED-1:0]       edge_miss;

    logic n_valid;
    logic n_hit;
    logic r_valid;
    logic r_hit;

    always_comb begin
        for (int e = 0; e < NED; e++) begin
            l_ext[e] = $signed(i_sum.lhs[e]);
            d_ext[e] = $signed(i_sum.diff[e]);
            d_abs[e] = d_ext[e][AW-1] ? -d_ext[e] : d_ext[e];
            edge_miss[e] = l_ext[e] < d_abs[e];
        end
        n_valid = i_sum.valid;
        n_hit   = !i_sum.face_miss && !(|edge_miss);
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

/* design/ray_aabb_overlap_test_core.sv */
// Ray versus axis-aligned box separating-axis test, top level.
// A test taken with start passes the prep, mul, acc and cmp registers to o_valid and o_hit.
// Throughput: one test per cycle; four register stages, the products in stage two
// set the depth, and busy stays low.
// Reset: synchronous active-low i_rst_n clears the stage valid bits; data is not reset.
`timescale 1ns / 1ps
module ray_aabb_overlap_test_core
    import rao_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [CW-1:0]  i_origin_x,
    input  logic signed [CW-1:0]  i_origin_y,
    input  logic signed [CW-1:0]  i_origin_z,
    input  logic signed [CW-1:0]  i_dir_x,
    input  logic signed [CW-1:0]  i_dir_y,
    input  logic signed [CW-1:0]  i_dir_z,
    input  logic signed [CW-1:0]  i_box_min_x,
    input  logic signed [CW-1:0]  i_box_min_y,
    input  logic signed [CW-1:0]  i_box_min_z,
    input  logic signed [CW-1:0]  i_box_max_x,
    input  logic signed [CW-1:0]  i_box_max_y,
    input  logic signed [CW-1:0]  i_box_max_z,
    output logic                  o_valid,
    output logic                  o_hit
);

`include "ray_aabb_overlap_test_core_assert.svh"

    logic [NAX-1:0][CW-1:0] origin;
    logic [NAX-1:0][CW-1:0] dir;
    logic [NAX-1:0][CW-1:0] bmin;
    logic [NAX-1:0][CW-1:0] bmax;
    logic                   in_valid;

    t_prep s_prep;
    t_prod s_prod;
    t_sum  s_sum;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    assign origin = {i_origin_z, i_origin_y, i_origin_x};
    assign dir    = {i_dir_z, i_dir_y, i_dir_x};
    assign bmin   = {i_box_min_z, i_box_min_y, i_box_min_x};
    assign bmax   = {i_box_max_z, i_box_max_y, i_box_max_x};

    rao_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_origin (origin),
        .i_dir    (dir),
        .i_bmin   (bmin),
        .i_bmax   (bmax),
        .o_prep   (s_prep)
    );

    rao_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prep  (s_prep),
        .o_prod  (s_prod)
    );

    rao_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (s_prod),
        .o_sum   (s_sum)
    );

    rao_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sum   (s_sum),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

    `RAO_ASSERT_IMPLY(a_no_spurious_word, o_valid, $past(start, 4), "result word without a start")
    `RAO_ASSERT_IMPLY(a_no_lost_word, $past(start && i_rst_n, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1), o_valid, "accepted test produced no result word")
    `RAO_ASSERT_NEXT(a_face_miss_clears_hit, s_sum.valid && s_sum.face_miss, o_valid && !o_hit, "face miss reported as hit")

endmodule
